// ----- src/bls_pkg.sv -----
// Package for the line stepper: register indexes, reset values, glyph codes and
// the structs passed between the stepper's modules. Depends on nothing.
package bls_pkg;

   localparam int CFG_BITS = 10;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;
   typedef logic [CFG_BITS-1:0] cfg_type;

   localparam csr_idx_type CSR_SCREEN_HEIGHT = 2'd0;
   localparam csr_idx_type CSR_SCREEN_WIDTH  = 2'd1;
   localparam csr_idx_type CSR_DASH_PERIOD   = 2'd2;
   localparam csr_idx_type CSR_DASH_PHASE    = 2'd3;

   localparam cfg_type RST_SCREEN_HEIGHT = 10'd24;
   localparam cfg_type RST_SCREEN_WIDTH  = 10'd80;
   localparam cfg_type RST_DASH_PERIOD   = 10'd1;
   localparam cfg_type RST_DASH_PHASE    = 10'd0;

   typedef logic [1:0] glyph_type;

   localparam glyph_type GLYPH_HORIZ = 2'd0;
   localparam glyph_type GLYPH_VERT  = 2'd1;
   localparam glyph_type GLYPH_BACK  = 2'd2;
   localparam glyph_type GLYPH_SLASH = 2'd3;

   typedef struct packed {
      glyph_type glyph;
      logic      visible;
      logic      last;
   } pt_flags_type;

   typedef struct packed {
      logic    busy;
      cfg_type phase_rem;
   } rem_status_type;

endpackage

// ----- src/bls_rem_unit.sv -----
// Restoring remainder unit: dash phase modulo dash period, one quotient bit per
// cycle. Depends on bls_pkg.
module bls_rem_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bls_pkg::cfg_type       period,
   input  bls_pkg::cfg_type       phase,
   output bls_pkg::rem_status_type status
);

   localparam int ITERS = bls_pkg::CFG_BITS;
   localparam int ITER_BITS = $clog2(ITERS);

   logic                  start_ff;
   logic                  run_ff;
   logic [ITER_BITS-1:0]  iter_ff;
   bls_pkg::cfg_type      div_ff;
   bls_pkg::cfg_type      num_ff;
   bls_pkg::cfg_type      rem_ff;
   bls_pkg::cfg_type      rem_in;
   logic [bls_pkg::CFG_BITS:0] trial;

   always_comb begin
      trial = {rem_ff, num_ff[bls_pkg::CFG_BITS-1]};
      if (trial >= {1'b0, div_ff}) begin
         trial = trial - {1'b0, div_ff};
      end
      rem_in = trial[bls_pkg::CFG_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
         run_ff   <= 1'b0;
         iter_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         start_ff <= start;
         if (start) begin
            run_ff <= 1'b0;
         end else if (start_ff) begin
            run_ff  <= 1'b1;
            iter_ff <= '0;
            rem_ff  <= '0;
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == ITER_BITS'(ITERS - 1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_ff) begin
         div_ff <= period;
         num_ff <= phase;
      end else if (run_ff) begin
         num_ff <= {num_ff[bls_pkg::CFG_BITS-2:0], 1'b0};
      end
   end

   assign status.busy      = start_ff | run_ff;
   assign status.phase_rem = rem_ff;

endmodule

// ----- src/bls_core.sv -----
// Line state and the combinational step: load or advance, glyph, visibility and
// end-of-line test. Depends on bls_pkg.
module bls_core #(
   parameter int COORD_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          func,
   input  logic signed [COORD_BITS-1:0]  start_row,
   input  logic signed [COORD_BITS-1:0]  start_col,
   input  logic signed [COORD_BITS-1:0]  end_row,
   input  logic signed [COORD_BITS-1:0]  end_col,
   input  bls_pkg::cfg_type              height,
   input  bls_pkg::cfg_type              width,
   input  bls_pkg::cfg_type              period,
   input  bls_pkg::cfg_type              phase_rem,
   output logic                          res_valid,
   output logic signed [COORD_BITS-1:0]  res_row,
   output logic signed [COORD_BITS-1:0]  res_col,
   output bls_pkg::pt_flags_type         res_flags,
   output logic                          line_active
);

   localparam int W  = COORD_BITS;
   localparam int DW = W + 1;
   localparam int EW = W + 2;
   localparam int CW = ((W > bls_pkg::CFG_BITS) ? W : bls_pkg::CFG_BITS) + 1;

   logic signed [W-1:0]  cur_row_ff, cur_col_ff, goal_row_ff, goal_col_ff;
   logic                 row_neg_ff, col_neg_ff;
   logic [DW-1:0]        delta_row_ff, delta_col_ff;
   logic signed [EW-1:0] error_ff;
   bls_pkg::cfg_type     dash_count_ff;
   logic                 active_ff;

   logic signed [W-1:0]  cur_row_in, cur_col_in, goal_row_in, goal_col_in;
   logic                 row_neg_in, col_neg_in;
   logic [DW-1:0]        delta_row_in, delta_col_in;
   logic signed [EW-1:0] error_in;
   bls_pkg::cfg_type     dash_count_in;

   logic signed [DW-1:0] diff_row, diff_col;
   logic signed [EW-1:0] dr_ext, dc_ext, neg_dc;
   logic                 mc, mr, on_screen, dash_hit, fin;
   logic [bls_pkg::CFG_BITS:0] count_inc, dash_sum;
   bls_pkg::glyph_type   glyph;

   always_comb begin
      diff_row = {end_row[W-1], end_row} - {start_row[W-1], start_row};
      diff_col = {end_col[W-1], end_col} - {start_col[W-1], start_col};
      dr_ext   = {2'b00, delta_row_ff[DW-2:0]};
      dc_ext   = {2'b00, delta_col_ff[DW-2:0]};
      neg_dc   = -dc_ext;
      mc       = error_ff > neg_dc;
      mr       = error_ff < dr_ext;
      count_inc = {1'b0, dash_count_ff} + 1'b1;

      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      goal_row_in   = goal_row_ff;
      goal_col_in   = goal_col_ff;
      row_neg_in    = row_neg_ff;
      col_neg_in    = col_neg_ff;
      delta_row_in  = delta_row_ff;
      delta_col_in  = delta_col_ff;
      error_in      = error_ff;
      dash_count_in = dash_count_ff;

      if (!func) begin
         cur_row_in    = start_row;
         cur_col_in    = start_col;
         goal_row_in   = end_row;
         goal_col_in   = end_col;
         row_neg_in    = !(start_row < end_row);
         col_neg_in    = !(start_col < end_col);
         delta_row_in  = diff_row[DW-1] ? DW'(-diff_row) : DW'(diff_row);
         delta_col_in  = diff_col[DW-1] ? DW'(-diff_col) : DW'(diff_col);
         if (delta_col_in > delta_row_in) begin
            error_in = {2'b00, delta_col_in[DW-1:1]};
         end else begin
            error_in = -{2'b00, delta_row_in[DW-1:1]};
         end
         dash_count_in = '0;
         glyph = (row_neg_in == col_neg_in) ? bls_pkg::GLYPH_BACK : bls_pkg::GLYPH_SLASH;
      end else begin
         if (mc) begin
            error_in   = error_in - dr_ext;
            cur_col_in = col_neg_ff ? cur_col_ff - W'(1) : cur_col_ff + W'(1);
         end
         if (mr) begin
            error_in   = error_in + dc_ext;
            cur_row_in = row_neg_ff ? cur_row_ff - W'(1) : cur_row_ff + W'(1);
         end
         if (mr != mc) begin
            glyph = mr ? bls_pkg::GLYPH_VERT : bls_pkg::GLYPH_HORIZ;
         end else begin
            glyph = (row_neg_ff == col_neg_ff) ? bls_pkg::GLYPH_BACK
                                               : bls_pkg::GLYPH_SLASH;
         end
         dash_count_in = (count_inc >= {1'b0, period}) ? '0
                                                        : count_inc[bls_pkg::CFG_BITS-1:0];
      end

      on_screen = !cur_row_in[W-1] && !cur_col_in[W-1] &&
                  ({{(CW-W+1){1'b0}}, cur_row_in[W-2:0]} <
                   {{(CW-bls_pkg::CFG_BITS){1'b0}}, height}) &&
                  ({{(CW-W+1){1'b0}}, cur_col_in[W-2:0]} <
                   {{(CW-bls_pkg::CFG_BITS){1'b0}}, width});
      dash_sum = {1'b0, dash_count_in} + {1'b0, phase_rem};
      dash_hit = (dash_sum == '0) || (dash_sum == {1'b0, period});
      fin      = (cur_row_in == goal_row_in) && (cur_col_in == goal_col_in);
   end

   assign res_valid         = accept && (!func || active_ff);
   assign res_row           = cur_row_in;
   assign res_col           = cur_col_in;
   assign res_flags.glyph   = glyph;
   assign res_flags.visible = on_screen && dash_hit;
   assign res_flags.last    = fin;
   assign line_active       = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (res_valid) begin
         active_ff <= !fin;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         goal_row_ff   <= goal_row_in;
         goal_col_ff   <= goal_col_in;
         row_neg_ff    <= row_neg_in;
         col_neg_ff    <= col_neg_in;
         delta_row_ff  <= delta_row_in;
         delta_col_ff  <= delta_col_in;
         error_ff      <= error_in;
         dash_count_ff <= dash_count_in;
      end
   end

endmodule

// ----- src/bls_rsp_buf.sv -----
// Result register with a skid stage behind it, so the stepper can take one more
// item while a result waits. Depends on bls_pkg.
module bls_rsp_buf #(
   parameter int COORD_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  in_row,
   input  logic signed [COORD_BITS-1:0]  in_col,
   input  bls_pkg::pt_flags_type         in_flags,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [COORD_BITS-1:0]  rsp_row,
   output logic signed [COORD_BITS-1:0]  rsp_col,
   output bls_pkg::pt_flags_type         rsp_flags,
   output logic                          skid_valid
);

   logic                          main_valid_ff, skid_valid_ff;
   logic                          main_valid_in, skid_valid_in;
   logic signed [COORD_BITS-1:0]  main_row_ff, main_col_ff, skid_row_ff, skid_col_ff;
   bls_pkg::pt_flags_type         main_flags_ff, skid_flags_ff;
   logic                          main_load, skid_load, from_skid;

   always_comb begin
      main_load     = !main_valid_ff || !rsp_stall;
      from_skid     = skid_valid_ff;
      skid_load     = !main_load && in_valid;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_load) begin
         main_valid_in = skid_valid_ff || in_valid;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (main_load) begin
         main_row_ff   <= from_skid ? skid_row_ff : in_row;
         main_col_ff   <= from_skid ? skid_col_ff : in_col;
         main_flags_ff <= from_skid ? skid_flags_ff : in_flags;
      end
      if (skid_load) begin
         skid_row_ff   <= in_row;
         skid_col_ff   <= in_col;
         skid_flags_ff <= in_flags;
      end
   end

   assign rsp_valid  = main_valid_ff;
   assign rsp_row    = main_row_ff;
   assign rsp_col    = main_col_ff;
   assign rsp_flags  = main_flags_ff;
   assign skid_valid = skid_valid_ff;

endmodule

// ----- src/bresenham_line_glyph_stepper.sv -----
// Top level of the line stepper: control registers, stepper core, phase
// remainder unit and result buffer. Depends on bls_pkg and the bls_ modules.
//
//   channel  direction  flow control     moves
//   req      in         valid / stall    func, start and end points
//   rsp      out        valid / stall    point, glyph, visible, last
//   csr      in         valid / ready    register index and write data
//
// One item is taken per cycle while not stalled; its result, set by one add,
// compare and select stage over the line state, lands in the output or skid
// register. A write to dash_period or dash_phase holds req_stall high while the
// remainder unit computes the phase modulo the period, one bit a cycle. Reset
// is synchronous; afterwards no line is active and the registers hold their
// reset values. A stalled rsp side is absorbed by a one-entry skid stage.
module bresenham_line_glyph_stepper #(
   parameter int COORD_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [COORD_BITS-1:0]  req_start_row,
   input  logic signed [COORD_BITS-1:0]  req_start_col,
   input  logic signed [COORD_BITS-1:0]  req_end_row,
   input  logic signed [COORD_BITS-1:0]  req_end_col,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]  rsp_point_row,
   output logic signed [COORD_BITS-1:0]  rsp_point_col,
   output logic [1:0]                    rsp_glyph,
   output logic                          rsp_visible,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  bls_pkg::csr_idx_type          csr_index,
   input  bls_pkg::cfg_type              csr_wdata
);

   bls_pkg::cfg_type        height_ff, width_ff, period_ff, phase_ff;
   bls_pkg::cfg_type        period_eff;
   bls_pkg::rem_status_type rem_status;
   bls_pkg::pt_flags_type   core_flags, buf_flags;
   logic signed [COORD_BITS-1:0] core_row, core_col;
   logic csr_write, rem_start, req_accept, core_valid, skid_valid, line_active;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign rem_start  = csr_write && ((csr_index == bls_pkg::CSR_DASH_PERIOD) ||
                                     (csr_index == bls_pkg::CSR_DASH_PHASE));
   assign period_eff = (period_ff == '0) ? bls_pkg::cfg_type'(1) : period_ff;
   assign req_stall  = rem_status.busy || skid_valid;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= bls_pkg::RST_SCREEN_HEIGHT;
         width_ff  <= bls_pkg::RST_SCREEN_WIDTH;
         period_ff <= bls_pkg::RST_DASH_PERIOD;
         phase_ff  <= bls_pkg::RST_DASH_PHASE;
      end else if (csr_write) begin
         unique case (csr_index)
            bls_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            bls_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            bls_pkg::CSR_DASH_PERIOD:   period_ff <= csr_wdata;
            bls_pkg::CSR_DASH_PHASE:    phase_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bls_rem_unit u_rem (
      .clock  (clock),
      .reset  (reset),
      .start  (rem_start),
      .period (period_eff),
      .phase  (phase_ff),
      .status (rem_status)
   );

   bls_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .func        (req_func),
      .start_row   (req_start_row),
      .start_col   (req_start_col),
      .end_row     (req_end_row),
      .end_col     (req_end_col),
      .height      (height_ff),
      .width       (width_ff),
      .period      (period_eff),
      .phase_rem   (rem_status.phase_rem),
      .res_valid   (core_valid),
      .res_row     (core_row),
      .res_col     (core_col),
      .res_flags   (core_flags),
      .line_active (line_active)
   );

   bls_rsp_buf #(
      .COORD_BITS (COORD_BITS)
   ) u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (core_valid),
      .in_row     (core_row),
      .in_col     (core_col),
      .in_flags   (core_flags),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_row    (rsp_point_row),
      .rsp_col    (rsp_point_col),
      .rsp_flags  (buf_flags),
      .skid_valid (skid_valid)
   );

   assign rsp_glyph   = buf_flags.glyph;
   assign rsp_visible = buf_flags.visible;
   assign rsp_last    = buf_flags.last;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid |-> rsp_valid)
      else $error("skid entry held without a result in the output register");

   a_load_emits: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_func) |-> core_valid)
      else $error("line load transfer produced no result");

   a_visible_on_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_visible) |->
         (!rsp_point_row[COORD_BITS-1] && !rsp_point_col[COORD_BITS-1]))
      else $error("visible point has a negative coordinate");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (core_valid && core_flags.last) |=> !line_active)
      else $error("line still active after its end point");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for bresenham_line_glyph_stepper: drives line loads and advances,
// predicts every emitted point with its own stepper model and checks each transfer.
// Depends on bls_pkg and the stepper RTL.
module tb;

   localparam int CW = 11;
   localparam bit FUNC_LOAD = 1'b0;
   localparam bit FUNC_ADVANCE = 1'b1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 6;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type          row;
      coord_type          col;
      bls_pkg::glyph_type glyph;
      logic               visible;
      logic               last;
   } line_point_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = 1'b0;
   coord_type            req_start_row = '0;
   coord_type            req_start_col = '0;
   coord_type            req_end_row = '0;
   coord_type            req_end_col = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   coord_type            rsp_point_row;
   coord_type            rsp_point_col;
   logic [1:0]           rsp_glyph;
   logic                 rsp_visible;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   bls_pkg::csr_idx_type csr_index = bls_pkg::CSR_SCREEN_HEIGHT;
   bls_pkg::cfg_type     csr_wdata = '0;

   int height_cfg = int'(bls_pkg::RST_SCREEN_HEIGHT);
   int width_cfg = int'(bls_pkg::RST_SCREEN_WIDTH);
   int period_cfg = int'(bls_pkg::RST_DASH_PERIOD);
   int phase_cfg = int'(bls_pkg::RST_DASH_PHASE);
   int row_pos, col_pos, row_goal, col_goal, row_dist, col_dist, err_term, dash_idx;
   bit row_neg, col_neg, drawing;

   line_point_type pending_points[$];
   line_point_type head_point;
   int items_sent = 0;
   int mismatches = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count;

   bresenham_line_glyph_stepper #(.COORD_BITS(CW)) uut (.*);

   initial forever #1 clock = ~clock;

   function automatic coord_type rand_coord();
      logic [31:0] r;
      r = $urandom;
      return r[CW-1:0];
   endfunction

   function automatic int period_used();
      return (period_cfg == 0) ? 1 : period_cfg;
   endfunction

   function automatic bls_pkg::glyph_type diagonal_glyph();
      return (row_neg == col_neg) ? bls_pkg::GLYPH_BACK : bls_pkg::GLYPH_SLASH;
   endfunction

   function automatic void emit_point(bls_pkg::glyph_type g);
      line_point_type pt;
      int p;
      int sum;
      bit on_screen;
      p = period_used();
      sum = (dash_idx % p) + (phase_cfg % p);
      on_screen = row_pos >= 0 && col_pos >= 0 && row_pos < height_cfg && col_pos < width_cfg;
      pt.row = row_pos[CW-1:0];
      pt.col = col_pos[CW-1:0];
      pt.glyph = g;
      pt.visible = on_screen && (sum % p == 0);
      pt.last = (row_pos == row_goal) && (col_pos == col_goal);
      if (pt.last) drawing = 1'b0;
      pending_points.insert(pending_points.size(), pt);
   endfunction

   // Returns 1 when the item emits a point.
   function automatic bit step_line_model(bit func, coord_type sr, coord_type sc,
                                          coord_type er, coord_type ec);
      int init;
      int e2;
      int p;
      bit moved_row;
      bit moved_col;
      bls_pkg::glyph_type step_glyph;
      if (func == FUNC_LOAD) begin
         row_pos = int'(sr);
         col_pos = int'(sc);
         row_goal = int'(er);
         col_goal = int'(ec);
         row_dist = (row_goal > row_pos) ? row_goal - row_pos : row_pos - row_goal;
         col_dist = (col_goal > col_pos) ? col_goal - col_pos : col_pos - col_goal;
         row_neg = !(row_pos < row_goal);
         col_neg = !(col_pos < col_goal);
         init = (col_dist > row_dist) ? col_dist : -row_dist;
         err_term = init / 2;
         dash_idx = 0;
         drawing = 1'b1;
         emit_point(diagonal_glyph());
         return 1'b1;
      end
      if (!drawing) return 1'b0;
      e2 = err_term;
      moved_row = 1'b0;
      moved_col = 1'b0;
      p = period_used();
      if (e2 > -col_dist) begin
         err_term -= row_dist;
         col_pos += col_neg ? -1 : 1;
         moved_col = 1'b1;
      end
      if (e2 < row_dist) begin
         err_term += col_dist;
         row_pos += row_neg ? -1 : 1;
         moved_row = 1'b1;
      end
      if (moved_row != moved_col) begin
         step_glyph = moved_row ? bls_pkg::GLYPH_VERT : bls_pkg::GLYPH_HORIZ;
      end else begin
         step_glyph = diagonal_glyph();
      end
      dash_idx = (dash_idx + 1 >= p) ? 0 : dash_idx + 1;
      emit_point(step_glyph);
      return 1'b1;
   endfunction

   task automatic send_item(input bit func, input coord_type sr, input coord_type sc,
                            input coord_type er, input coord_type ec);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_start_row <= sr;
      req_start_col <= sc;
      req_end_row <= er;
      req_end_col <= ec;
      do @(posedge clock); while (req_stall);
      items_sent++;
      void'(step_line_model(func, sr, sc, er, ec));
   endtask

   task automatic load_line(input coord_type sr, input coord_type sc, input coord_type er,
                            input coord_type ec);
      send_item(FUNC_LOAD, sr, sc, er, ec);
   endtask

   task automatic advance(input int count);
      repeat (count) send_item(FUNC_ADVANCE, rand_coord(), rand_coord(), rand_coord(),
                               rand_coord());
   endtask

   // An advance with no line may still be in flight when the queue empties.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input bls_pkg::csr_idx_type idx, input int value);
      bls_pkg::cfg_type v;
      v = value[bls_pkg::CFG_BITS-1:0];
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bls_pkg::CSR_SCREEN_HEIGHT: height_cfg = int'(v);
         bls_pkg::CSR_SCREEN_WIDTH: width_cfg = int'(v);
         bls_pkg::CSR_DASH_PERIOD: period_cfg = int'(v);
         bls_pkg::CSR_DASH_PHASE: phase_cfg = int'(v);
         default: ;
      endcase
   endtask

   task automatic set_config(input int h, input int w, input int period, input int phase);
      settle_block();
      write_reg(bls_pkg::CSR_SCREEN_HEIGHT, h);
      write_reg(bls_pkg::CSR_SCREEN_WIDTH, w);
      write_reg(bls_pkg::CSR_DASH_PERIOD, period);
      write_reg(bls_pkg::CSR_DASH_PHASE, phase);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      // After reset no line is loaded, so this advance must not produce a transfer.
      advance(1);
      load_line(0, 0, 0, 0);
      advance(1);
      load_line(5, 5, 5, 10);
      advance(5);
      load_line(2, 3, -1, 3);
      advance(3);
      load_line(0, 0, 2, 2);
      advance(2);
      load_line(0, 5, 3, 2);
      advance(1);
      load_line(-1024, 1023, 1023, -1024);
      advance(2);
      load_line(1023, -1024, -1024, 1023);
      advance(1);
   endtask

   task automatic test_dash_and_screen();
      set_config(0, 0, 0, 0);
      load_line(0, 0, 0, 3);
      advance(3);
      set_config(1, 1, 1, 0);
      load_line(0, 0, 1, 1);
      advance(1);
      set_config(1023, 1023, 3, 5);
      load_line(0, 0, 0, 8);
      advance(8);
      set_config(24, 80, 4, 1);
      load_line(1, 1, 6, 3);
      advance(5);
      set_config(1023, 1023, 1023, 1023);
      load_line(-3, 1020, 3, 1023);
      advance(6);
      // The period shrinks below the point index while a line is in progress.
      set_config(20, 20, 5, 0);
      load_line(0, 0, 0, 9);
      advance(4);
      set_config(20, 20, 2, 1);
      advance(6);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
      int goal_count;
      int kind;
      int span_r;
      int span_c;
      int r;
      int c;
      coord_type sr;
      coord_type sc;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      goal_count = items_sent + target;
      while (items_sent < goal_count) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            span_r = (height_cfg > 1000) ? 1000 : height_cfg;
            span_c = (width_cfg > 1000) ? 1000 : width_cfg;
            r = $urandom_range(0, span_r + 12);
            c = $urandom_range(0, span_c + 12);
            sr = coord_type'(r - 6);
            sc = coord_type'(c - 6);
            if ($urandom_range(9) == 0) begin
               load_line(sr, sc, rand_coord(), rand_coord());
            end else begin
               r = $urandom_range(0, 24);
               c = $urandom_range(0, 24);
               load_line(sr, sc, coord_type'(sr + r - 12), coord_type'(sc + c - 12));
            end
            advance($urandom_range(0, 16));
         end else if (kind < 92) begin
            send_item(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord());
         end else begin
            advance($urandom_range(1, 3));
         end
      end
   endtask

   task automatic test_random_traffic();
      set_config(int'(bls_pkg::RST_SCREEN_HEIGHT), int'(bls_pkg::RST_SCREEN_WIDTH),
                 int'(bls_pkg::RST_DASH_PERIOD), int'(bls_pkg::RST_DASH_PHASE));
      run_phase(0, 0, 88);
      set_config(12, 40, 3, 2);
      run_phase(59, 0, 88);
      set_config($urandom_range(1, 64), $urandom_range(1, 100), $urandom_range(1, 8),
                 $urandom_range(0, 1023));
      run_phase(0, 59, 88);
      set_config(30, 60, 2, 1);
      run_phase(11, 11, 88);
      set_config($urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023));
      run_phase(0, 0, 88);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $error("transfer with no point pending: row %0d col %0d",
                   rsp_point_row, rsp_point_col);
            mismatches++;
         end else begin
            head_point = pending_points.pop_front();
            if (rsp_point_row !== head_point.row) begin
               $error("point_row: expected %0d, got %0d", head_point.row, rsp_point_row);
               mismatches++;
            end
            if (rsp_point_col !== head_point.col) begin
               $error("point_col: expected %0d, got %0d", head_point.col, rsp_point_col);
               mismatches++;
            end
            if (rsp_glyph !== head_point.glyph) begin
               $error("glyph: expected %0d, got %0d", head_point.glyph, rsp_glyph);
               mismatches++;
            end
            if (rsp_visible !== head_point.visible) begin
               $error("visible: expected %0b, got %0b", head_point.visible, rsp_visible);
               mismatches++;
            end
            if (rsp_last !== head_point.last) begin
               $error("last: expected %0b, got %0b", head_point.last, rsp_last);
               mismatches++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** bresenham_line_glyph_stepper: FAILED **");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_dash_and_screen();
      test_random_traffic();
      settle_block();
      if (mismatches == 0)
         $display("** bresenham_line_glyph_stepper: PASSED **");
      else
         $display("** bresenham_line_glyph_stepper: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/bls_pkg.sv
src/bls_rem_unit.sv
src/bls_core.sv
src/bls_rsp_buf.sv
src/bresenham_line_glyph_stepper.sv
bench/tb.sv
